### hdl/yds_pkg.sv
// shared constants and types of the yuv box downscaler
`default_nettype none
package yds_pkg;
  localparam int MaxOutWidth = 256;
  localparam int MaxSrcDim   = 2048;
  localparam int MaxBlock    = 32;
  localparam int MaxOutHeight = 256;
  localparam int SumW  = 20;
  localparam int DenW  = 18;
  localparam int MeanW = 17;
  localparam int NumW  = SumW + 16;
  localparam int CntW  = $clog2(NumW);
  localparam int AddrW = $clog2(MaxOutWidth);

  localparam logic [2:0] RegSrcWidth   = 3'd0;
  localparam logic [2:0] RegSrcHeight  = 3'd1;
  localparam logic [2:0] RegBlockWidth = 3'd2;
  localparam logic [2:0] RegBlockHeight = 3'd3;
  localparam logic [2:0] RegOutWidth   = 3'd4;
  localparam logic [2:0] RegOutHeight  = 3'd5;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] sum;
    logic [DenW-1:0] den;
  } lane_req_t;
endpackage
`default_nettype wire

### hdl/yds_lane.sv
// one channel lane: restoring divider for the normalized block mean
`default_nettype none
module yds_lane (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire yds_pkg::lane_req_t       req_i,
  output logic                          done_o,
  output logic [yds_pkg::MeanW-1:0]     mean_o
);
  logic                         busy_q;
  logic                         done_q;
  logic [yds_pkg::CntW-1:0]     cnt_q;
  logic [yds_pkg::NumW-1:0]     num_q;
  logic [yds_pkg::DenW-1:0]     rem_q;
  logic [yds_pkg::DenW-1:0]     den_q;
  logic [yds_pkg::DenW:0]       trial;
  logic                         fit;

  assign trial = {rem_q, num_q[yds_pkg::NumW-1]};
  assign fit   = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= yds_pkg::CntW'(yds_pkg::NumW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= {req_i.sum, 16'd0};
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      num_q <= {num_q[yds_pkg::NumW-2:0], fit};
      rem_q <= fit ? yds_pkg::DenW'(trial - {1'b0, den_q}) : trial[yds_pkg::DenW-1:0];
    end
  end

  assign done_o = done_q;
  assign mean_o = num_q[yds_pkg::MeanW-1:0];
endmodule
`default_nettype wire

### hdl/yuv_box_downscaler.sv
// top level of the yuv box downscaler: counters, line store, lanes, merge
// Usage:
//   in channel: pixel_y/u/v with in_valid_i; in_stall_o high while busy.
//   out channel: block means in Q1.16 plus output coordinates and frame_end,
//   held in an output register until taken (out_valid_o high, out_stall_i low).
//   cfg channel: cfg_valid_i with cfg_index_i/cfg_data_i, always ready;
//   write only while idle.
// Per pixel: a pixel that closes no block passes a line store read, then
//   update and write back. A pixel that closes a block adds the 36-step
//   restoring divider, run in each of the three channel lanes, and the load
//   of the output register; in_stall_o holds the next pixel off until that load.
// A stalled receiver holds the output register; the next pixel is still
//   accepted and summed, only a further result waits in the lanes.
// Reset: registers return to 640x480 source, 8x8 blocks, 80x60 output,
//   counters clear; the line store needs no clearing since a block's first
//   pixel ignores the value read and overwrites the entry.
`default_nettype none
module yuv_box_downscaler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  pixel_y_i,
  input  wire logic [7:0]  pixel_u_i,
  input  wire logic [7:0]  pixel_v_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [16:0]      mean_y_o,
  output logic [16:0]      mean_u_o,
  output logic [16:0]      mean_v_o,
  output logic [7:0]       out_x_o,
  output logic [7:0]       out_y_o,
  output logic             frame_end_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  localparam int SW = yds_pkg::SumW;

  logic [1:0]  state_q, state_d;
  logic [11:0] src_width_q, src_height_q;
  logic [5:0]  block_width_q, block_height_q;
  logic [8:0]  out_width_q, out_height_q;

  logic [10:0] scol_q, srow_q;
  logic [4:0]  cib_q, rib_q;
  logic [8:0]  ocol_q, orow_q;

  logic [7:0]  px_q [3];
  logic [3*SW-1:0] mem [yds_pkg::MaxOutWidth];
  logic [3*SW-1:0] rd_q;
  logic [3*SW-1:0] wr_data;

  logic [11:0] sw, sh;
  logic [11:0] bw_c, bh_c, ow_c, oh_c;
  logic [5:0]  bw, bh;
  logic [8:0]  ow, oh;
  logic        last_col, last_row, covered, first, emit, row_end, frame_wrap;
  logic [11:0] area;
  logic [19:0] den_full;

  logic [7:0]  ox_q, oy_q;
  logic        fe_q;
  logic        out_valid_q;
  logic [16:0] mean_q [3];
  yds_pkg::lane_req_t req [3];
  logic        done [3];
  logic [16:0] mean [3];
  logic        all_done, out_free;

  function automatic logic [11:0] clamp12(input logic [11:0] v, input logic [11:0] hi);
    logic [11:0] r;
    r = (v == '0) ? 12'd1 : ((v > hi) ? hi : v);
    return r;
  endfunction

  assign sw   = clamp12(src_width_q, 12'(yds_pkg::MaxSrcDim));
  assign sh   = clamp12(src_height_q, 12'(yds_pkg::MaxSrcDim));
  assign bw_c = clamp12({6'd0, block_width_q}, 12'(yds_pkg::MaxBlock));
  assign bh_c = clamp12({6'd0, block_height_q}, 12'(yds_pkg::MaxBlock));
  assign ow_c = clamp12({3'd0, out_width_q}, 12'(yds_pkg::MaxOutWidth));
  assign oh_c = clamp12({3'd0, out_height_q}, 12'(yds_pkg::MaxOutHeight));
  assign bw   = bw_c[5:0];
  assign bh   = bh_c[5:0];
  assign ow   = ow_c[8:0];
  assign oh   = oh_c[8:0];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= 12'd640;
      src_height_q   <= 12'd480;
      block_width_q  <= 6'd8;
      block_height_q <= 6'd8;
      out_width_q    <= 9'd80;
      out_height_q   <= 9'd60;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        yds_pkg::RegSrcWidth:    src_width_q    <= cfg_data_i;
        yds_pkg::RegSrcHeight:   src_height_q   <= cfg_data_i;
        yds_pkg::RegBlockWidth:  block_width_q  <= cfg_data_i[5:0];
        yds_pkg::RegBlockHeight: block_height_q <= cfg_data_i[5:0];
        yds_pkg::RegOutWidth:    out_width_q    <= cfg_data_i[8:0];
        yds_pkg::RegOutHeight:   out_height_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign last_col = ({1'b0, cib_q} + 6'd1) >= bw;
  assign last_row = ({1'b0, rib_q} + 6'd1) >= bh;
  assign covered  = (ocol_q < ow) && (orow_q < oh);
  assign first    = (cib_q == '0) && (rib_q == '0);
  assign emit     = covered && last_col && last_row;
  assign row_end  = ({1'b0, scol_q} + 12'd1) >= sw;
  assign frame_wrap = ({1'b0, srow_q} + 12'd1) >= sh;
  assign area     = 12'(bw * bh);
  assign den_full = ({8'd0, area} << 8) - {8'd0, area};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wr_data[c*SW +: SW] = first ? {12'd0, px_q[c]}
                                  : SW'(rd_q[c*SW +: SW] + {12'd0, px_q[c]});
    end
  end

  assign all_done = done[0] && done[1] && done[2];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_UPD;
      S_UPD:  state_d = emit ? S_DIV : S_IDLE;
      S_DIV:  if (all_done && out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scol_q <= '0; srow_q <= '0; cib_q <= '0; rib_q <= '0;
      ocol_q <= '0; orow_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DIV && all_done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_UPD) begin
        if (row_end) begin
          scol_q <= '0;
          cib_q  <= '0;
          ocol_q <= '0;
          if (frame_wrap) begin
            srow_q <= '0;
            rib_q  <= '0;
            orow_q <= '0;
          end else begin
            srow_q <= srow_q + 11'd1;
            if (orow_q < oh) begin
              if (last_row) begin
                rib_q  <= '0;
                orow_q <= orow_q + 9'd1;
              end else begin
                rib_q <= rib_q + 5'd1;
              end
            end
          end
        end else begin
          scol_q <= scol_q + 11'd1;
          if (covered) begin
            if (last_col) begin
              cib_q  <= '0;
              ocol_q <= ocol_q + 9'd1;
            end else begin
              cib_q <= cib_q + 5'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      px_q[0] <= pixel_y_i;
      px_q[1] <= pixel_u_i;
      px_q[2] <= pixel_v_i;
      rd_q    <= mem[ocol_q[yds_pkg::AddrW-1:0]];
    end
    if (state_q == S_UPD && covered) begin
      mem[ocol_q[yds_pkg::AddrW-1:0]] <= wr_data;
    end
    if (state_q == S_UPD && emit) begin
      ox_q <= ocol_q[7:0];
      oy_q <= orow_q[7:0];
      fe_q <= (({1'b0, ocol_q} + 10'd1) >= {1'b0, ow})
           && (({1'b0, orow_q} + 10'd1) >= {1'b0, oh});
    end
    if (state_q == S_DIV && all_done && out_free) begin
      for (int c = 0; c < 3; c++) mean_q[c] <= mean[c];
      out_x_o     <= ox_q;
      out_y_o     <= oy_q;
      frame_end_o <= fe_q;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign req[g].start = (state_q == S_UPD) && emit;
    assign req[g].sum   = wr_data[g*SW +: SW];
    assign req[g].den   = den_full[yds_pkg::DenW-1:0];
    yds_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req[g]),
      .done_o (done[g]),
      .mean_o (mean[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign mean_y_o = mean_q[0];
  assign mean_u_o = mean_q[1];
  assign mean_v_o = mean_q[2];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_UPD))
    else $error("no update after accepted item");
  a_upd_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (state_q == S_IDLE || state_q == S_DIV))
    else $error("bad state after update");
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && emit) |=> !all_done)
    else $error("lanes done right after start");
endmodule
`default_nettype wire
